>>> src/rbd_pkg.sv
`timescale 1ns / 1ps

package rbd_pkg;

   localparam int SCALE_FACTOR  = 4;
   localparam int SCALE_LOG2    = $clog2(SCALE_FACTOR);
   localparam int MAX_WIDTH     = 4096;
   localparam int HEIGHT_LIMIT  = 4096;
   localparam int LINE_DEPTH    = MAX_WIDTH / SCALE_FACTOR;
   localparam int ADDR_W        = $clog2(LINE_DEPTH);
   localparam int CHANNELS      = 4;
   localparam int PIX_W         = 8;
   localparam int ROW_SUM_W     = PIX_W + SCALE_LOG2;
   localparam int COL_SUM_W     = PIX_W + 2 * SCALE_LOG2;
   localparam int LINE_W        = CHANNELS * COL_SUM_W;
   localparam int DIM_W         = 13;
   localparam int CNT_W         = 12;
   localparam int CSR_ADDR_W    = 3;
   localparam int CSR_DATA_W    = 32;

   localparam logic [DIM_W-1:0] WIDTH_RESET  = DIM_W'(640);
   localparam logic [DIM_W-1:0] HEIGHT_RESET = DIM_W'(480);

   localparam logic REG_IMAGE_WIDTH  = 1'b0;
   localparam logic REG_IMAGE_HEIGHT = 1'b1;

   typedef struct packed {
      logic take;
      logic close_blk;
      logic row_end;
   } lane_ctl_type;

   function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                  input logic [DIM_W-1:0] hi);
      logic [DIM_W-1:0] r;
      r = v;
      if (v == '0) begin
         r = DIM_W'(1);
      end else if (v > hi) begin
         r = hi;
      end
      return r;
   endfunction

endpackage

>>> src/rbd_line_store.sv
`timescale 1ns / 1ps

module rbd_line_store (
   input  logic                         clock,
   input  logic                         rd_en,
   input  logic [rbd_pkg::ADDR_W-1:0]   rd_addr,
   output logic [rbd_pkg::LINE_W-1:0]   rd_data,
   input  logic                         wr_en,
   input  logic [rbd_pkg::ADDR_W-1:0]   wr_addr,
   input  logic [rbd_pkg::LINE_W-1:0]   wr_data
);

   logic [rbd_pkg::LINE_W-1:0] mem [rbd_pkg::LINE_DEPTH];
   logic [rbd_pkg::LINE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> src/rbd_lane.sv
`timescale 1ns / 1ps

module rbd_lane (
   input  logic                            clock,
   input  logic                            reset,
   input  rbd_pkg::lane_ctl_type           ctl,
   input  logic [rbd_pkg::PIX_W-1:0]       pixel,
   input  logic                            first_row,
   input  logic [rbd_pkg::COL_SUM_W-1:0]   col_prev,
   output logic [rbd_pkg::COL_SUM_W-1:0]   col_acc
);

   logic [rbd_pkg::ROW_SUM_W-1:0] row_sum_ff;
   logic [rbd_pkg::ROW_SUM_W-1:0] row_sum_in;
   logic [rbd_pkg::ROW_SUM_W-1:0] blk_sum_ff;
   logic [rbd_pkg::ROW_SUM_W-1:0] blk_sum_in;
   logic [rbd_pkg::ROW_SUM_W-1:0] sum_add;

   always_comb begin
      sum_add    = row_sum_ff + rbd_pkg::ROW_SUM_W'(pixel);
      row_sum_in = row_sum_ff;
      blk_sum_in = blk_sum_ff;
      if (ctl.take) begin
         if (ctl.close_blk) begin
            blk_sum_in = sum_add;
            row_sum_in = '0;
         end else begin
            row_sum_in = sum_add;
         end
      end
      // drop partial sums at the end of each row
      if (ctl.row_end) begin
         row_sum_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_sum_ff <= '0;
      end else begin
         row_sum_ff <= row_sum_in;
      end
   end

   always_ff @(posedge clock) begin
      blk_sum_ff <= blk_sum_in;
   end

   assign col_acc = rbd_pkg::COL_SUM_W'(blk_sum_ff)
                  + (first_row ? '0 : col_prev);

endmodule

>>> src/rgba_box_downscale_4x4.sv
`timescale 1ns / 1ps

// 4x4 box-filter thumbnail of an RGBA raster stream. One pixel is accepted per clock cycle;
// the only stall comes from the result register when a thumbnail pixel is not taken. In each
// pixel's path, four channel lanes add it to the current block-row sum, and on the fourth
// pixel of each block row the 1024 x 48-bit line store is read and, from the accumulate
// stage register, written back with the column sum. A result passes the accumulate stage
// and the result register and carries tlast on the frame's last thumbnail pixel. Widths and
// heights of 0 act as 1 and are capped at 4096; partial blocks at the right and bottom
// edges are dropped. The line store needs no clearing after reset.
module rgba_box_downscale_4x4 (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [31:0]                       req_tdata,   // red_in, green_in, blue_in, alpha_in
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [31:0]                       rsp_tdata,   // red_avg, green_avg, blue_avg, alpha_avg
   output logic                              rsp_tlast,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [rbd_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [rbd_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [rbd_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                              csr_pready
);

   localparam int CW  = rbd_pkg::COL_SUM_W;
   localparam int SL  = rbd_pkg::SCALE_LOG2;
   localparam int BXW = rbd_pkg::CNT_W - SL;
   localparam int DW  = rbd_pkg::DIM_W;

   logic [DW-1:0] width_ff, width_in;
   logic [DW-1:0] height_ff, height_in;
   logic          csr_wr;

   logic [rbd_pkg::CNT_W-1:0] col_ff, col_in;
   logic [rbd_pkg::CNT_W-1:0] row_ff, row_in;

   logic                      s1_valid_ff, s1_valid_in;
   logic [rbd_pkg::ADDR_W-1:0] s1_bx_ff;
   logic                      s1_first_ff;
   logic                      s1_emit_ff;
   logic                      s1_last_ff;
   logic                      s1_adv;

   logic                      out_valid_ff, out_valid_in;
   logic [31:0]               out_data_ff;
   logic                      out_last_ff;

   logic [DW-1:0]             w_eff, h_eff;
   logic [DW-SL-1:0]          blocks_x, blocks_y;
   logic [BXW-1:0]            bx, by;
   logic [SL-1:0]             sub_x, sub_y;
   logic                      in_range;
   logic                      accept;
   logic                      col_wrap, row_wrap;
   logic                      blk_last;
   rbd_pkg::lane_ctl_type     ctl;

   logic [rbd_pkg::LINE_W-1:0] rd_data;
   logic [rbd_pkg::LINE_W-1:0] wr_data;
   logic [CW-1:0]              col_acc [rbd_pkg::CHANNELS];
   logic [31:0]                avg_word;

   // configuration
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_wr) begin
         case (csr_paddr[SL])
            rbd_pkg::REG_IMAGE_WIDTH:  width_in  = csr_pwdata[DW-1:0];
            rbd_pkg::REG_IMAGE_HEIGHT: height_in = csr_pwdata[DW-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[SL])
         rbd_pkg::REG_IMAGE_WIDTH:  csr_prdata = rbd_pkg::CSR_DATA_W'(width_ff);
         rbd_pkg::REG_IMAGE_HEIGHT: csr_prdata = rbd_pkg::CSR_DATA_W'(height_ff);
         default:                   csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= rbd_pkg::WIDTH_RESET;
         height_ff <= rbd_pkg::HEIGHT_RESET;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
      end
   end

   // position and block decode
   always_comb begin
      w_eff    = rbd_pkg::clamp_dim(width_ff, DW'(rbd_pkg::MAX_WIDTH));
      h_eff    = rbd_pkg::clamp_dim(height_ff, DW'(rbd_pkg::HEIGHT_LIMIT));
      blocks_x = w_eff[DW-1:SL];
      blocks_y = h_eff[DW-1:SL];
      bx       = col_ff[rbd_pkg::CNT_W-1:SL];
      by       = row_ff[rbd_pkg::CNT_W-1:SL];
      sub_x    = col_ff[SL-1:0];
      sub_y    = row_ff[SL-1:0];
      in_range = ((DW-SL)'(bx) < blocks_x) && ((DW-SL)'(by) < blocks_y);
      blk_last = ((DW-SL)'(bx) == blocks_x - 1'b1) && ((DW-SL)'(by) == blocks_y - 1'b1);
      col_wrap = (DW'(col_ff) + 1'b1) >= w_eff;
      row_wrap = (DW'(row_ff) + 1'b1) >= h_eff;
      accept   = req_tvalid & req_tready;

      ctl.take      = accept & in_range;
      ctl.close_blk = (sub_x == '1);
      ctl.row_end   = accept & col_wrap;

      col_in = col_ff;
      row_in = row_ff;
      if (accept) begin
         if (col_wrap) begin
            col_in = '0;
            row_in = row_wrap ? '0 : row_ff + 1'b1;
         end else begin
            col_in = col_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // column accumulate stage
   assign s1_adv     = s1_valid_ff & (~s1_emit_ff | ~out_valid_ff | rsp_tready);
   assign req_tready = ~s1_valid_ff | s1_adv;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (ctl.take & ctl.close_blk) begin
         s1_valid_in = 1'b1;
      end else if (s1_adv) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.take & ctl.close_blk) begin
         s1_bx_ff    <= bx[rbd_pkg::ADDR_W-1:0];
         s1_first_ff <= (sub_y == '0);
         s1_emit_ff  <= (sub_y == '1);
         s1_last_ff  <= blk_last;
      end
   end

   for (genvar c = 0; c < rbd_pkg::CHANNELS; c++) begin : g_lane
      rbd_lane u_lane (
         .clock     (clock),
         .reset     (reset),
         .ctl       (ctl),
         .pixel     (req_tdata[c*rbd_pkg::PIX_W +: rbd_pkg::PIX_W]),
         .first_row (s1_first_ff),
         .col_prev  (rd_data[c*CW +: CW]),
         .col_acc   (col_acc[c])
      );
      assign wr_data[c*CW +: CW] = col_acc[c];
      assign avg_word[c*rbd_pkg::PIX_W +: rbd_pkg::PIX_W] = col_acc[c][CW-1 -: rbd_pkg::PIX_W];
   end

   rbd_line_store u_line_store (
      .clock   (clock),
      .rd_en   (ctl.take & ctl.close_blk),
      .rd_addr (bx[rbd_pkg::ADDR_W-1:0]),
      .rd_data (rd_data),
      .wr_en   (s1_adv),
      .wr_addr (s1_bx_ff),
      .wr_data (wr_data)
   );

   // result register
   always_comb begin
      out_valid_in = out_valid_ff;
      if (s1_adv & s1_emit_ff) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv & s1_emit_ff) begin
         out_data_ff <= avg_word;
         out_last_ff <= s1_last_ff;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tlast  = out_last_ff;

endmodule
